@@ hw/rtl/assert_macros.svh @@
// Assertion macros for the RTL files; sha1s_ctrl.sv includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define SHA1S_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SHA1S_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SHA1S_ASSERT(label, clk, rst, prop, msg)
`define SHA1S_ASSERT_NR(label, clk, prop, msg)
`endif

`endif

@@ hw/rtl/sha1s_pkg.sv @@
package sha1s_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_present;
      logic       last;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        final_word;
   } rsp_type;

   typedef enum logic [1:0] {
      SEL_DATA,
      SEL_PAD,
      SEL_ZERO,
      SEL_LEN
   } byte_sel_type;

   typedef enum logic [1:0] {
      STG_CHOOSE,
      STG_PARITY_LO,
      STG_MAJORITY,
      STG_PARITY_HI
   } stage_type;

   typedef struct packed {
      logic         wr_en;
      byte_sel_type byte_sel;
      logic         count_inc;
      logic         load_vars;
      logic         round_en;
      stage_type    stage;
      logic         finalize;
      logic         init;
      logic [2:0]   word_index;
   } cmd_type;

   typedef struct packed {
      logic [5:0] fill;
   } sts_type;

   localparam logic [31:0] K_CHOOSE    = 32'h5a827999;
   localparam logic [31:0] K_PARITY_LO = 32'h6ed9eba1;
   localparam logic [31:0] K_MAJORITY  = 32'h8f1bbcdc;
   localparam logic [31:0] K_PARITY_HI = 32'hca62c1d6;

   localparam logic [31:0] IV_WORDS [5] = '{
      32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
   };

   localparam logic [7:0] PAD_BYTE   = 8'h80;
   localparam logic [5:0] LAST_POS   = 6'h3f;
   localparam logic [5:0] LEN_POS    = 6'd56;
   localparam logic [6:0] LAST_ROUND = 7'd79;
   localparam logic [2:0] LAST_WORD  = 3'd4;

endpackage

@@ hw/rtl/sha1s_datapath.sv @@
module sha1s_datapath
   import sha1s_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  cmd_type cmd,
   input  logic [7:0] data_byte,
   output sts_type sts,
   output rsp_type rsp_data
);

   logic [31:0] chain_ff [5];
   logic [31:0] chain_in [5];
   logic [31:0] vars_ff [5];
   logic [31:0] vars_in [5];
   logic [31:0] sched_ff [16];
   logic [60:0] count_ff;
   logic [60:0] count_in;
   logic [5:0]  fill_ff;
   logic [5:0]  fill_in;
   logic [63:0] bit_len;
   logic [7:0]  wr_byte;
   logic [31:0] func_f;
   logic [31:0] round_k;
   logic [31:0] round_sum;
   logic [31:0] sched_new;

   function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
      logic [63:0] dbl;
      dbl = {x, x} << n;
      return dbl[63:32];
   endfunction

   assign bit_len = {count_ff, 3'b000};

   always_comb begin
      case (cmd.byte_sel)
         SEL_DATA: wr_byte = data_byte;
         SEL_PAD:  wr_byte = PAD_BYTE;
         SEL_ZERO: wr_byte = 8'h00;
         SEL_LEN:  wr_byte = bit_len[{~fill_ff[2:0], 3'b000} +: 8];
         default:  wr_byte = 8'h00;
      endcase
   end

   always_comb begin
      case (cmd.stage)
         STG_CHOOSE: begin
            func_f  = vars_ff[3] ^ (vars_ff[1] & (vars_ff[2] ^ vars_ff[3]));
            round_k = K_CHOOSE;
         end
         STG_PARITY_LO: begin
            func_f  = vars_ff[1] ^ vars_ff[2] ^ vars_ff[3];
            round_k = K_PARITY_LO;
         end
         STG_MAJORITY: begin
            func_f  = (vars_ff[1] & vars_ff[2]) | (vars_ff[3] & (vars_ff[1] | vars_ff[2]));
            round_k = K_MAJORITY;
         end
         STG_PARITY_HI: begin
            func_f  = vars_ff[1] ^ vars_ff[2] ^ vars_ff[3];
            round_k = K_PARITY_HI;
         end
         default: begin
            func_f  = '0;
            round_k = '0;
         end
      endcase
   end

   assign round_sum = rotl(vars_ff[0], 5) + func_f + vars_ff[4] + round_k + sched_ff[0];
   assign sched_new = rotl(sched_ff[13] ^ sched_ff[8] ^ sched_ff[2] ^ sched_ff[0], 1);

   always_comb begin
      chain_in = chain_ff;
      vars_in  = vars_ff;
      count_in = count_ff;
      fill_in  = fill_ff;
      if (cmd.wr_en) begin
         fill_in = fill_ff + 6'd1;
      end
      if (cmd.count_inc) begin
         count_in = count_ff + 61'd1;
      end
      if (cmd.load_vars) begin
         vars_in = chain_ff;
      end
      if (cmd.round_en) begin
         vars_in[0] = round_sum;
         vars_in[1] = vars_ff[0];
         vars_in[2] = rotl(vars_ff[1], 30);
         vars_in[3] = vars_ff[2];
         vars_in[4] = vars_ff[3];
      end
      if (cmd.finalize) begin
         for (int i = 0; i < 5; i++) begin
            chain_in[i] = chain_ff[i] + vars_ff[i];
         end
      end
      if (cmd.init) begin
         chain_in = IV_WORDS;
         count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff <= IV_WORDS;
         vars_ff  <= '{default: '0};
         count_ff <= '0;
         fill_ff  <= '0;
      end else begin
         chain_ff <= chain_in;
         vars_ff  <= vars_in;
         count_ff <= count_in;
         fill_ff  <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         sched_ff[fill_ff[5:2]][{~fill_ff[1:0], 3'b000} +: 8] <= wr_byte;
      end else if (cmd.round_en) begin
         for (int i = 0; i < 15; i++) begin
            sched_ff[i] <= sched_ff[i + 1];
         end
         sched_ff[15] <= sched_new;
      end
   end

   assign sts.fill = fill_ff;

   assign rsp_data.digest_word = chain_ff[cmd.word_index];
   assign rsp_data.word_index  = cmd.word_index;
   assign rsp_data.final_word  = (cmd.word_index == LAST_WORD);

endmodule

@@ hw/rtl/sha1s_ctrl.sv @@
`include "assert_macros.svh"

module sha1s_ctrl
   import sha1s_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_ROUND = 7'b0000010,
      S_FINAL = 7'b0000100,
      S_PAD   = 7'b0001000,
      S_ZERO  = 7'b0010000,
      S_LEN   = 7'b0100000,
      S_EMIT  = 7'b1000000
   } state_type;

   state_type  state_ff;
   state_type  state_in;
   state_type  ret_ff;
   state_type  ret_in;
   logic [6:0] round_ff;
   logic [6:0] round_in;
   logic [2:0] widx_ff;
   logic [2:0] widx_in;
   stage_type  stage;

   always_comb begin
      case (round_ff) inside
         [7'd0:7'd19]:  stage = STG_CHOOSE;
         [7'd20:7'd39]: stage = STG_PARITY_LO;
         [7'd40:7'd59]: stage = STG_MAJORITY;
         default:       stage = STG_PARITY_HI;
      endcase
   end

   always_comb begin
      cmd            = '0;
      cmd.byte_sel   = SEL_DATA;
      cmd.stage      = stage;
      cmd.word_index = widx_ff;
      state_in       = state_ff;
      ret_in         = ret_ff;
      round_in       = round_ff;
      widx_in        = widx_ff;
      req_stall      = 1'b1;
      rsp_valid      = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               if (req_data.byte_present) begin
                  cmd.wr_en     = 1'b1;
                  cmd.count_inc = 1'b1;
               end
               if (req_data.byte_present && sts.fill == LAST_POS) begin
                  cmd.load_vars = 1'b1;
                  round_in      = '0;
                  state_in      = S_ROUND;
                  ret_in        = req_data.last ? S_PAD : S_IDLE;
               end else if (req_data.last) begin
                  state_in = S_PAD;
               end
            end
         end
         S_ROUND: begin
            cmd.round_en = 1'b1;
            round_in     = round_ff + 7'd1;
            if (round_ff == LAST_ROUND) begin
               state_in = S_FINAL;
            end
         end
         S_FINAL: begin
            cmd.finalize = 1'b1;
            state_in     = ret_ff;
         end
         S_PAD: begin
            cmd.wr_en    = 1'b1;
            cmd.byte_sel = SEL_PAD;
            state_in     = S_ZERO;
            if (sts.fill == LAST_POS) begin
               cmd.load_vars = 1'b1;
               round_in      = '0;
               state_in      = S_ROUND;
               ret_in        = S_ZERO;
            end
         end
         S_ZERO: begin
            if (sts.fill == LEN_POS) begin
               state_in = S_LEN;
            end else begin
               cmd.wr_en    = 1'b1;
               cmd.byte_sel = SEL_ZERO;
               if (sts.fill == LAST_POS) begin
                  cmd.load_vars = 1'b1;
                  round_in      = '0;
                  state_in      = S_ROUND;
                  ret_in        = S_ZERO;
               end
            end
         end
         S_LEN: begin
            cmd.wr_en    = 1'b1;
            cmd.byte_sel = SEL_LEN;
            if (sts.fill == LAST_POS) begin
               cmd.load_vars = 1'b1;
               round_in      = '0;
               state_in      = S_ROUND;
               ret_in        = S_EMIT;
            end
         end
         S_EMIT: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               if (widx_ff == LAST_WORD) begin
                  cmd.init = 1'b1;
                  widx_in  = '0;
                  state_in = S_IDLE;
               end else begin
                  widx_in = widx_ff + 3'd1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ret_ff   <= S_IDLE;
         round_ff <= '0;
         widx_ff  <= '0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         round_ff <= round_in;
         widx_ff  <= widx_in;
      end
   end

   `SHA1S_ASSERT(a_round_exit, clock, reset, (state_ff == S_ROUND && round_ff == LAST_ROUND) |=> (state_ff == S_FINAL), "Compression did not finish after the last round.")
   `SHA1S_ASSERT(a_emit_aligned, clock, reset, (state_ff == S_EMIT) |-> (sts.fill == 6'd0), "Digest emitted with a partly filled block.")
   `SHA1S_ASSERT(a_last_leaves_idle, clock, reset, (state_ff == S_IDLE && req_valid && req_data.last) |=> (state_ff != S_IDLE), "Final request did not start padding.")
   `SHA1S_ASSERT(a_word_range, clock, reset, rsp_valid |-> (widx_ff <= LAST_WORD), "Digest word index out of range.")
   `SHA1S_ASSERT_NR(a_reset_idle, clock, reset |=> (state_ff == S_IDLE && widx_ff == 3'd0), "Controller not idle after reset.")

endmodule

@@ hw/rtl/sha1_stream_hasher.sv @@
// A request without a completed block is accepted while idle and its byte, if present,
// is stored; a request that fills a block loads the working variables, runs 80 rounds,
// one per cycle, and folds them into the chaining value while requests stall. A final
// request adds the padding byte, zero bytes up to the length field, the length bytes,
// one or two compressions, and five digest responses, one per cycle when not stalled.
// Synchronous active-high reset returns the chaining value to the initial constants,
// clears the byte count and leaves the block idle and ready for a request.
module sha1_stream_hasher
   import sha1s_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   cmd_type cmd;
   sts_type sts;

   sha1s_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   sha1s_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .data_byte (req_data.data_byte),
      .sts       (sts),
      .rsp_data  (rsp_data)
   );

endmodule
